### design/dma_channel_address_sequencer_macros.svh
// Assertion macros for the DMA channel address sequencer checker.
// Depends on nothing; included by the checker file.
`ifndef DMA_CHANNEL_ADDRESS_SEQUENCER_MACROS_SVH
`define DMA_CHANNEL_ADDRESS_SEQUENCER_MACROS_SVH

// Property checked on every rising edge, ignored while reset is high.
`define DCAS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, including during reset.
`define DCAS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/dcas_pkg.sv
// Shared constants, types and helper functions of the DMA channel address sequencer.
// Depends on nothing; used by every other design file except the macros header.
`timescale 1ns / 1ps

package dcas_pkg;

  // Channel configuration
  localparam int CHANNEL        = 3;
  localparam int EEPROM_CHANNEL = 3;
  localparam int COUNT_LIMIT    = 65536;
  localparam int CNT_W          = $clog2(COUNT_LIMIT);
  localparam int UNITS_W        = CNT_W + 1;
  localparam logic [UNITS_W-1:0] UNITS_FULL = UNITS_W'(1) << CNT_W;

  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [ADDR_W-1:0] EEPROM_LOW  = 32'h0D00_0000;
  localparam logic [ADDR_W-1:0] EEPROM_HIGH = 32'h0E00_0000;

  // Request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_UNIT  = 1'b1;

  // Address step modes
  localparam logic [1:0] MODE_INC        = 2'd0;
  localparam logic [1:0] MODE_DEC        = 2'd1;
  localparam logic [1:0] MODE_FIXED      = 2'd2;
  localparam logic [1:0] MODE_INC_RELOAD = 2'd3;

  // Transfer kinds
  localparam logic [1:0] KIND_HALF      = 2'd0;
  localparam logic [1:0] KIND_WORD      = 2'd1;
  localparam logic [1:0] KIND_EE_READ   = 2'd2;
  localparam logic [1:0] KIND_EE_WRITE  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLAGS       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP_EE   = 3'd6;

  // Bit positions in transfer_flags
  localparam int FLAG_WORD   = 0;
  localparam int FLAG_REPEAT = 1;
  localparam int FLAG_IRQ    = 2;

  typedef struct packed {
    logic [ADDR_W-1:0]  source_base;
    logic [ADDR_W-1:0]  dest_base;
    logic [COUNT_W-1:0] unit_count;
    logic [1:0]         source_mode;
    logic [1:0]         dest_mode;
    logic [2:0]         transfer_flags;
    logic               backup_is_eeprom;
  } cfg_t;

  typedef struct packed {
    logic              transfer_valid;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic [1:0]        transfer_kind;
    logic              last_unit;
    logic              irq_request;
    logic              enabled_after;
    logic              busy_res;
  } result_t;

  // Two's complement byte step for a mode and unit size
  function automatic logic [STEP_W-1:0] step_code(logic [1:0] mode, logic word);
    logic [STEP_W-1:0] size;
    size = word ? 4'd4 : 4'd2;
    case (mode)
      MODE_INC, MODE_INC_RELOAD: step_code = size;
      MODE_DEC:                  step_code = 4'd0 - size;
      MODE_FIXED:                step_code = '0;
      default:                   step_code = '0;
    endcase
  endfunction

  function automatic logic in_eeprom_window(logic [ADDR_W-1:0] a);
    in_eeprom_window = (a >= EEPROM_LOW) && (a < EEPROM_HIGH);
  endfunction

endpackage

### design/dcas_ifs.sv
// Channel interfaces of the DMA channel address sequencer: request, result, config.
// Depends on dcas_pkg.
`timescale 1ns / 1ps

interface dcas_item_if import dcas_pkg::*; ();
  logic valid;
  logic ready;
  logic op;
  logic reload_addresses;

  modport source (output valid, op, reload_addresses, input ready);
  modport sink   (input valid, op, reload_addresses, output ready);
endinterface

interface dcas_result_if import dcas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              transfer_valid;
  logic [ADDR_W-1:0] source_address;
  logic [ADDR_W-1:0] dest_address;
  logic [1:0]        transfer_kind;
  logic              last_unit;
  logic              irq_request;
  logic              enabled_after;
  logic              busy_res;

  modport source (output valid, transfer_valid, source_address, dest_address,
                  transfer_kind, last_unit, irq_request, enabled_after, busy_res,
                  input ready);
  modport sink   (input valid, transfer_valid, source_address, dest_address,
                  transfer_kind, last_unit, irq_request, enabled_after, busy_res,
                  output ready);
endinterface

interface dcas_cfg_if import dcas_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/dcas_cfg_regs.sv
// Configuration register file of the DMA channel address sequencer.
// Depends on dcas_pkg and dcas_cfg_if.
`timescale 1ns / 1ps

module dcas_cfg_regs import dcas_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dcas_cfg_if.sink  cfg,
  output cfg_t      regs
);

  // Writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SOURCE_BASE: regs.source_base      <= cfg.data[ADDR_W-1:0];
        REG_DEST_BASE:   regs.dest_base        <= cfg.data[ADDR_W-1:0];
        REG_UNIT_COUNT:  regs.unit_count       <= cfg.data[COUNT_W-1:0];
        REG_SOURCE_MODE: regs.source_mode      <= cfg.data[1:0];
        REG_DEST_MODE:   regs.dest_mode        <= cfg.data[1:0];
        REG_FLAGS:       regs.transfer_flags   <= cfg.data[2:0];
        REG_BACKUP_EE:   regs.backup_is_eeprom <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

### design/dcas_engine.sv
// Channel state and per-request logic: start setup and per-unit address stepping.
// Depends on dcas_pkg.
`timescale 1ns / 1ps

module dcas_engine import dcas_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  logic    op,
  input  logic    reload_addresses,
  input  cfg_t    regs,
  output result_t res
);

  logic                running_flag, running_flag_next;
  logic [UNITS_W-1:0]  units_left, units_left_next;
  logic [ADDR_W-1:0]   current_source, current_source_next;
  logic [ADDR_W-1:0]   current_dest, current_dest_next;
  logic [STEP_W-1:0]   source_step, source_step_next;
  logic [STEP_W-1:0]   dest_step, dest_step_next;
  logic [1:0]          latched_kind, latched_kind_next;

  logic                word, repeat_en, irq_en;
  logic [ADDR_W-1:0]   align_mask, src_sel, dst_sel, src_al, dst_al;
  logic [CNT_W-1:0]    cnt;
  logic                ee_w, ee_r;
  logic [UNITS_W-1:0]  units_dec;

  assign word      = regs.transfer_flags[FLAG_WORD];
  assign repeat_en = regs.transfer_flags[FLAG_REPEAT];
  assign irq_en    = regs.transfer_flags[FLAG_IRQ];

  // Start path: address selection, alignment and kind decode
  assign align_mask = word ? ~ADDR_W'(3) : ~ADDR_W'(1);
  assign src_sel    = reload_addresses ? regs.source_base : current_source;
  assign dst_sel    = (reload_addresses ||
                       (repeat_en && regs.dest_mode == MODE_INC_RELOAD))
                      ? regs.dest_base : current_dest;
  assign src_al     = src_sel & align_mask;
  assign dst_al     = dst_sel & align_mask;
  assign cnt        = regs.unit_count[CNT_W-1:0];
  assign ee_w       = (CHANNEL == EEPROM_CHANNEL) && in_eeprom_window(dst_al);
  assign ee_r       = (CHANNEL == EEPROM_CHANNEL) && in_eeprom_window(src_al);
  assign units_dec  = units_left - UNITS_W'(1);

  always_comb begin
    res                 = '0;
    running_flag_next   = running_flag;
    units_left_next     = units_left;
    current_source_next = current_source;
    current_dest_next   = current_dest;
    source_step_next    = source_step;
    dest_step_next      = dest_step;
    latched_kind_next   = latched_kind;

    if (fire) begin
      if (op == OP_START) begin
        // Load count, addresses and steps; restarts a running channel
        running_flag_next   = 1'b1;
        units_left_next     = (cnt == '0) ? UNITS_FULL : UNITS_W'(cnt);
        current_source_next = src_al;
        current_dest_next   = dst_al;
        source_step_next    = step_code(regs.source_mode, word);
        dest_step_next      = step_code(regs.dest_mode, word);
        if ((ee_w || ee_r) && regs.backup_is_eeprom)
          latched_kind_next = ee_w ? KIND_EE_WRITE : KIND_EE_READ;
        else
          latched_kind_next = word ? KIND_WORD : KIND_HALF;
        res.busy_res = 1'b1;
      end else if (!running_flag || units_left == '0) begin
        // Unit request on an idle channel
        running_flag_next = 1'b0;
      end else begin
        // Issue one unit and advance both addresses
        res.transfer_valid  = 1'b1;
        res.source_address  = current_source;
        res.dest_address    = current_dest;
        res.transfer_kind   = latched_kind;
        current_source_next = current_source + {{(ADDR_W-STEP_W){source_step[STEP_W-1]}},
                                                source_step};
        current_dest_next   = current_dest + {{(ADDR_W-STEP_W){dest_step[STEP_W-1]}},
                                              dest_step};
        units_left_next     = units_dec;
        if (units_dec == '0) begin
          running_flag_next = 1'b0;
          res.last_unit     = 1'b1;
          res.irq_request   = irq_en;
          res.enabled_after = repeat_en;
        end else begin
          res.busy_res = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_flag   <= 1'b0;
      units_left     <= '0;
      current_source <= '0;
      current_dest   <= '0;
      source_step    <= '0;
      dest_step      <= '0;
      latched_kind   <= KIND_HALF;
    end else begin
      running_flag   <= running_flag_next;
      units_left     <= units_left_next;
      current_source <= current_source_next;
      current_dest   <= current_dest_next;
      source_step    <= source_step_next;
      dest_step      <= dest_step_next;
      latched_kind   <= latched_kind_next;
    end
  end

endmodule

### design/dma_channel_address_sequencer.sv
// Top level of the DMA channel address sequencer: request register, engine, result register.
// Depends on dcas_pkg, dcas_ifs, dcas_cfg_regs and dcas_engine.
`timescale 1ns / 1ps
//
// Usage
//   item   : requests in. op 0 starts the channel (reload_addresses picks a
//            reload of both addresses from the base registers); op 1 asks for
//            one transfer unit.
//   result : one result per request: the unit's addresses and kind, or a
//            start/idle acknowledgment, plus completion, irq and enable state.
//   cfg    : register writes (index, data); always ready. Write only while
//            no request is in flight.
// Timing
//   A request accepted on item is held in the request register, moves through
//   the engine into the result register and is presented on the result channel.
//   One request per cycle is sustained while result.ready stays high; each request
//   costs one pass through the engine (a 32-bit add per address, or the start setup).
// Reset
//   rst (synchronous) clears the valid bits of both pipeline registers, the
//   channel state and all configuration registers; the channel is stopped.
// Stalls
//   While result.ready is low a waiting result holds; the request register
//   still takes one more request, then item.ready drops.
//
module dma_channel_address_sequencer import dcas_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  dcas_item_if.sink     item,
  dcas_result_if.source result,
  dcas_cfg_if.sink      cfg
);

  cfg_t    regs;
  result_t res_next;
  result_t res_q;
  logic    req_valid;
  logic    req_op;
  logic    req_reload;
  logic    res_valid;
  logic    advance;

  dcas_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Request moves into the engine when the result register is empty or its result is taken
  assign advance    = req_valid && (!res_valid || result.ready);
  assign item.ready = !req_valid || advance;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (item.ready) begin
      req_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      req_op     <= item.op;
      req_reload <= item.reload_addresses;
    end
  end

  dcas_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .fire             (advance),
    .op               (req_op),
    .reload_addresses (req_reload),
    .regs             (regs),
    .res              (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.transfer_valid = res_q.transfer_valid;
  assign result.source_address = res_q.source_address;
  assign result.dest_address   = res_q.dest_address;
  assign result.transfer_kind  = res_q.transfer_kind;
  assign result.last_unit      = res_q.last_unit;
  assign result.irq_request    = res_q.irq_request;
  assign result.enabled_after  = res_q.enabled_after;
  assign result.busy_res       = res_q.busy_res;

endmodule

### design/dcas_checker.sv
// Port-level checker for the DMA channel address sequencer, bound to the top level.
// Depends on dcas_pkg and dma_channel_address_sequencer_macros.svh.
`timescale 1ns / 1ps
`include "dma_channel_address_sequencer_macros.svh"

module dcas_checker import dcas_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic              transfer_valid,
  input logic [ADDR_W-1:0] source_address,
  input logic [ADDR_W-1:0] dest_address,
  input logic [1:0]        transfer_kind,
  input logic              last_unit,
  input logic              irq_request,
  input logic              enabled_after,
  input logic              busy_res
);

  // A stalled result stays valid and keeps its addresses and completion flag
  `DCAS_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(source_address) && $stable(dest_address) && $stable(last_unit), "result changed while stalled")

  // No unit issued: all unit fields read zero
  `DCAS_ASSERT(a_no_unit_zero, clk, rst, res_valid && !transfer_valid |-> source_address == '0 && dest_address == '0 && transfer_kind == KIND_HALF && !last_unit && !irq_request && !enabled_after, "non-unit result carries unit fields")

  // Completion comes with a unit and stops the channel
  `DCAS_ASSERT(a_last_stops, clk, rst, res_valid && last_unit |-> transfer_valid && !busy_res, "completion without unit or with channel busy")

  // Interrupt and re-enable only on completion
  `DCAS_ASSERT(a_irq_on_last, clk, rst, res_valid && (irq_request || enabled_after) |-> last_unit, "irq or enable outside completion")

  // Reset empties the result register
  `DCAS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result valid right after reset")

endmodule

bind dma_channel_address_sequencer dcas_checker u_dcas_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .transfer_valid (result.transfer_valid),
  .source_address (result.source_address),
  .dest_address   (result.dest_address),
  .transfer_kind  (result.transfer_kind),
  .last_unit      (result.last_unit),
  .irq_request    (result.irq_request),
  .enabled_after  (result.enabled_after),
  .busy_res       (result.busy_res)
);
